[src/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)

`endif

`endif

[src/hmlv_pkg.sv]
package hmlv_pkg;

  // parser position within a token
  typedef enum logic [6:0] {
    PH_BETWEEN = 7'b0000001,
    PH_SIGN    = 7'b0000010,
    PH_DIGITS  = 7'b0000100,
    PH_COMMA   = 7'b0001000,
    PH_ZERO    = 7'b0010000,
    PH_HEX     = 7'b0100000,
    PH_SKIP    = 7'b1000000
  } phase_t;

  // line status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_WIDTH = 2'd2,
    ST_COLS  = 2'd3
  } status_t;

  // characters of the token grammar
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;

  // magnitude limit, saturated positive height and line count limit
  localparam logic [35:0] MAG_LIMIT = 36'h080000000;
  localparam logic [31:0] POS_MAX   = 32'h7FFFFFFF;
  localparam logic [15:0] LINES_MAX = 16'hFFFF;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= CH_LO_A) && (c <= CH_LO_F)) ||
           ((c >= CH_UP_A) && (c <= CH_UP_F));
  endfunction

endpackage

[src/height_map_line_validator_unit.sv]
// a character or end-of-line transaction enters an input register, then updates the parser
//   state and, on end of line, loads the result register
// throughput: one transaction per cycle, set by the single parser update stage; eol may stall
// reset: synchronous active-high rst clears parser, line and map state and empties both stages
`include "assert_macros.svh"

module height_map_line_validator_unit #(
  parameter int MAX_COLUMNS    = 4096,
  parameter int MAX_HEX_DIGITS = 6,
  localparam int COL_W   = $clog2(MAX_COLUMNS + 1),
  localparam int HEX_W   = $clog2(MAX_HEX_DIGITS + 1),
  localparam int OUT_W   = 2 + COL_W + 16 + 32 + 32,
  localparam int TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // character
  input  logic               s_axis_tlast,   // end_of_line
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // line_status, column_count, line_number, lowest height, highest height
  output logic [TDATA_W-1:0] m_axis_tdata
);

  localparam logic [COL_W-1:0] MAX_COL_C = COL_W'(MAX_COLUMNS);
  localparam logic [HEX_W-1:0] MAX_HEX_C = HEX_W'(MAX_HEX_DIGITS);

  // input register
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_eol;
  logic       advance;

  // parser and map state
  hmlv_pkg::phase_t  phase, phase_next;
  hmlv_pkg::status_t line_fault, line_fault_next;
  logic [HEX_W-1:0]  hex_cnt, hex_cnt_next;
  logic [31:0]       tok_val, tok_val_next;
  logic              tok_neg, tok_neg_next;
  logic [COL_W-1:0]  cols, cols_next;
  logic [COL_W-1:0]  exp_cols, exp_cols_next;
  logic              width_known, width_known_next;
  logic [31:0]       lowest, lowest_next;
  logic [31:0]       highest, highest_next;
  logic              heights_known, heights_known_next;
  logic [15:0]       lines_seen, lines_seen_next;
  logic              map_failed, map_failed_next;

  // result register
  logic              out_valid;
  hmlv_pkg::status_t res_status, res_status_next;
  logic [COL_W-1:0]  res_cols;
  logic [15:0]       res_lines;
  logic [31:0]       res_min;
  logic [31:0]       res_max;

  // the stage moves unless it holds an end of line and the result slot is blocked
  assign advance       = s1_valid && (!s1_eol || !out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      s1_char <= s_axis_tdata;
      s1_eol  <= s_axis_tlast;
    end
  end

  // parser update for one transaction
  always_comb begin
    logic [35:0] prod;
    logic [31:0] digit_val;
    logic [31:0] commit_val;
    logic        do_commit;
    logic        is_d;

    phase_next         = phase;
    line_fault_next    = line_fault;
    hex_cnt_next       = hex_cnt;
    tok_val_next       = tok_val;
    tok_neg_next       = tok_neg;
    cols_next          = cols;
    exp_cols_next      = exp_cols;
    width_known_next   = width_known;
    lowest_next        = lowest;
    highest_next       = highest;
    heights_known_next = heights_known;
    lines_seen_next    = lines_seen;
    map_failed_next    = map_failed;
    res_status_next    = line_fault;
    do_commit          = 1'b0;
    is_d               = hmlv_pkg::is_digit(s1_char);

    // token value times ten plus the new digit, saturated at the magnitude limit
    prod = {4'd0, tok_val} * 36'd10 + {28'd0, s1_char - hmlv_pkg::CH_ZERO};
    digit_val = (prod > hmlv_pkg::MAG_LIMIT) ? hmlv_pkg::MAG_LIMIT[31:0] : prod[31:0];

    // signed height of the finished digit run
    if (tok_neg) begin
      commit_val = 32'd0 - tok_val;
    end else begin
      commit_val = tok_val[31] ? hmlv_pkg::POS_MAX : tok_val;
    end

    if (!s1_eol) begin
      unique case (phase)
        hmlv_pkg::PH_BETWEEN: begin
          if (s1_char == hmlv_pkg::CH_SPACE) begin
            phase_next = hmlv_pkg::PH_BETWEEN;
          end else if (is_d || s1_char == hmlv_pkg::CH_PLUS ||
                       s1_char == hmlv_pkg::CH_MINUS) begin
            tok_val_next = 32'd0;
            tok_neg_next = 1'b0;
            hex_cnt_next = '0;
            if (cols >= MAX_COL_C) begin
              if (line_fault == hmlv_pkg::ST_OK) line_fault_next = hmlv_pkg::ST_COLS;
              phase_next = hmlv_pkg::PH_SKIP;
            end else begin
              cols_next = cols + COL_W'(1);
              if (is_d) begin
                tok_val_next = {28'd0, s1_char[3:0]};
                phase_next   = hmlv_pkg::PH_DIGITS;
              end else begin
                tok_neg_next = (s1_char == hmlv_pkg::CH_MINUS);
                phase_next   = hmlv_pkg::PH_SIGN;
              end
            end
          end else begin
            if (line_fault == hmlv_pkg::ST_OK) line_fault_next = hmlv_pkg::ST_BAD;
            phase_next = hmlv_pkg::PH_SKIP;
          end
        end
        hmlv_pkg::PH_SIGN: begin
          if (is_d) begin
            tok_val_next = digit_val;
            phase_next   = hmlv_pkg::PH_DIGITS;
          end else begin
            if (line_fault == hmlv_pkg::ST_OK) line_fault_next = hmlv_pkg::ST_BAD;
            phase_next = hmlv_pkg::PH_SKIP;
          end
        end
        hmlv_pkg::PH_DIGITS: begin
          if (is_d) begin
            tok_val_next = digit_val;
          end else if (s1_char == hmlv_pkg::CH_SPACE) begin
            do_commit  = 1'b1;
            phase_next = hmlv_pkg::PH_BETWEEN;
          end else if (s1_char == hmlv_pkg::CH_COMMA) begin
            do_commit  = 1'b1;
            phase_next = hmlv_pkg::PH_COMMA;
          end else begin
            if (line_fault == hmlv_pkg::ST_OK) line_fault_next = hmlv_pkg::ST_BAD;
            phase_next = hmlv_pkg::PH_SKIP;
          end
        end
        hmlv_pkg::PH_COMMA: begin
          if (s1_char == hmlv_pkg::CH_ZERO) begin
            phase_next = hmlv_pkg::PH_ZERO;
          end else begin
            if (line_fault == hmlv_pkg::ST_OK) line_fault_next = hmlv_pkg::ST_BAD;
            phase_next = hmlv_pkg::PH_SKIP;
          end
        end
        hmlv_pkg::PH_ZERO: begin
          if (s1_char == hmlv_pkg::CH_X) begin
            phase_next = hmlv_pkg::PH_HEX;
          end else begin
            if (line_fault == hmlv_pkg::ST_OK) line_fault_next = hmlv_pkg::ST_BAD;
            phase_next = hmlv_pkg::PH_SKIP;
          end
        end
        hmlv_pkg::PH_HEX: begin
          if (s1_char == hmlv_pkg::CH_SPACE && hex_cnt != '0) begin
            phase_next = hmlv_pkg::PH_BETWEEN;
          end else if (hmlv_pkg::is_hex(s1_char) && hex_cnt < MAX_HEX_C) begin
            hex_cnt_next = hex_cnt + HEX_W'(1);
          end else begin
            if (line_fault == hmlv_pkg::ST_OK) line_fault_next = hmlv_pkg::ST_BAD;
            phase_next = hmlv_pkg::PH_SKIP;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end else begin
      // close the line: finish or reject the open token, then check the width
      if (phase == hmlv_pkg::PH_DIGITS) begin
        do_commit = 1'b1;
      end else if (phase == hmlv_pkg::PH_SIGN || phase == hmlv_pkg::PH_COMMA ||
                   phase == hmlv_pkg::PH_ZERO ||
                   (phase == hmlv_pkg::PH_HEX && hex_cnt == '0)) begin
        if (line_fault == hmlv_pkg::ST_OK) line_fault_next = hmlv_pkg::ST_BAD;
      end
      if (line_fault_next == hmlv_pkg::ST_OK) begin
        if (!width_known) begin
          exp_cols_next    = cols;
          width_known_next = 1'b1;
        end else if (exp_cols != cols) begin
          line_fault_next = hmlv_pkg::ST_WIDTH;
        end
      end
      if (lines_seen != hmlv_pkg::LINES_MAX) lines_seen_next = lines_seen + 16'd1;
      // sticky map failure
      res_status_next = line_fault_next;
      if (line_fault_next != hmlv_pkg::ST_OK) begin
        map_failed_next = 1'b1;
      end else if (map_failed) begin
        res_status_next = hmlv_pkg::ST_BAD;
      end
      // per-line state back to its start
      phase_next      = hmlv_pkg::PH_BETWEEN;
      hex_cnt_next    = '0;
      tok_val_next    = 32'd0;
      tok_neg_next    = 1'b0;
      cols_next       = '0;
      line_fault_next = hmlv_pkg::ST_OK;
    end

    // running minimum and maximum
    if (do_commit) begin
      if (!heights_known) begin
        lowest_next        = commit_val;
        highest_next       = commit_val;
        heights_known_next = 1'b1;
      end else begin
        if ($signed(highest) < $signed(commit_val)) highest_next = commit_val;
        if ($signed(commit_val) < $signed(lowest)) lowest_next = commit_val;
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= hmlv_pkg::PH_BETWEEN;
      line_fault    <= hmlv_pkg::ST_OK;
      hex_cnt       <= '0;
      tok_val       <= 32'd0;
      tok_neg       <= 1'b0;
      cols          <= '0;
      exp_cols      <= '0;
      width_known   <= 1'b0;
      lowest        <= 32'd0;
      highest       <= 32'd0;
      heights_known <= 1'b0;
      lines_seen    <= 16'd0;
      map_failed    <= 1'b0;
    end else if (advance) begin
      phase         <= phase_next;
      line_fault    <= line_fault_next;
      hex_cnt       <= hex_cnt_next;
      tok_val       <= tok_val_next;
      tok_neg       <= tok_neg_next;
      cols          <= cols_next;
      exp_cols      <= exp_cols_next;
      width_known   <= width_known_next;
      lowest        <= lowest_next;
      highest       <= highest_next;
      heights_known <= heights_known_next;
      lines_seen    <= lines_seen_next;
      map_failed    <= map_failed_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_eol) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (advance && s1_eol) begin
      res_status <= res_status_next;
      res_cols   <= cols;
      res_lines  <= lines_seen_next;
      res_min    <= lowest_next;
      res_max    <= highest_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = TDATA_W'({res_max, res_min, res_lines, res_cols, res_status});

  // checks
  `ASSERT_IMPLY(a_min_le_max, clk, rst, out_valid, $signed(res_min) <= $signed(res_max), "min above max")
  `ASSERT_IMPLY(a_ok_width, clk, rst, out_valid && res_status == hmlv_pkg::ST_OK, width_known && exp_cols == res_cols, "ok line width differs")
  `ASSERT_ALWAYS(a_hex_bound, clk, rst, hex_cnt <= MAX_HEX_C, "hex digit count overflow")
  `ASSERT_ALWAYS(a_col_bound, clk, rst, cols <= MAX_COL_C && exp_cols <= MAX_COL_C, "column count overflow")

endmodule

[tb/sv/tb_height_map_line_validator_unit.sv]
module tb_height_map_line_validator_unit;

  localparam int MAX_COLS = 4096;
  localparam int MAX_HEX  = 6;
  localparam int REPORT_W = 96;
  localparam int RANDOM_ITEMS = 780;
  localparam int HOLD_CYCLES = 400;

  // one end-of-line report, with the block's fields in reverse bit order
  typedef struct packed {
    hmlv_pkg::status_t  status;
    logic [12:0]        cols;
    logic [15:0]        line;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } line_report_t;

  // one directed line: text repeated, optional raw byte appended
  typedef struct {
    string        text;
    bit           typed;
    line_report_t want;
    int           reps;
    logic [7:0]   tail;
    bit           has_tail;
  } map_row_t;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // character
  logic                s_axis_tlast;   // end_of_line
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // line_status, column_count, line_number, lowest height, highest height
  logic [REPORT_W-1:0] m_axis_tdata;

  height_map_line_validator_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // parser and map state of the line checker
  hmlv_pkg::phase_t   ph;
  logic [2:0]         hex_n;
  logic [31:0]        tok_val;
  logic               tok_neg;
  logic [12:0]        cols;
  logic [12:0]        want_cols;
  logic               width_set;
  logic signed [31:0] lo;
  logic signed [31:0] hi;
  logic               heights_set;
  logic [15:0]        line_cnt;
  hmlv_pkg::status_t  fault_code;
  logic               failed;

  line_report_t reports_due[$];
  map_row_t     rows[$];
  logic [7:0]   line_buf[$];

  int  burst_left;
  int  items_sent;
  int  lines_sent;
  int  reports_seen;
  int  mismatches;
  int  status_seen[4];
  bit  hold_req;
  bit  hold_done;
  bit  stim_done;

  function automatic bit dec_char(logic [7:0] c);
    return c >= hmlv_pkg::CH_ZERO && c <= hmlv_pkg::CH_NINE;
  endfunction

  function automatic bit hex_char(logic [7:0] c);
    return dec_char(c) || (c >= hmlv_pkg::CH_LO_A && c <= hmlv_pkg::CH_LO_F) ||
           (c >= hmlv_pkg::CH_UP_A && c <= hmlv_pkg::CH_UP_F);
  endfunction

  // first fault of a line is kept, rest of the line skipped
  function automatic void mark_fault(hmlv_pkg::status_t code);
    if (fault_code == hmlv_pkg::ST_OK) fault_code = code;
    ph = hmlv_pkg::PH_SKIP;
  endfunction

  // fold a finished height into the running min and max
  function automatic void commit_height();
    logic signed [31:0] v;
    if (tok_neg) v = -tok_val;
    else v = (tok_val >= 32'h8000_0000) ? 32'h7FFF_FFFF : tok_val;
    if (!heights_set) begin
      lo = v;
      hi = v;
      heights_set = 1'b1;
    end else begin
      if (v > hi) hi = v;
      if (v < lo) lo = v;
    end
  endfunction

  function automatic void open_token();
    tok_val = '0;
    tok_neg = 1'b0;
    hex_n = '0;
    if (cols >= 13'(MAX_COLS)) mark_fault(hmlv_pkg::ST_COLS);
    else cols = cols + 13'd1;
  endfunction

  // decimal accumulate, magnitude clamped at 2^31
  function automatic void push_digit(logic [7:0] c);
    logic [63:0] m;
    m = {32'b0, tok_val} * 64'd10 + 64'(c - hmlv_pkg::CH_ZERO);
    tok_val = (m > 64'h8000_0000) ? 32'h8000_0000 : m[31:0];
  endfunction

  function automatic void feed_char(logic [7:0] c);
    case (ph)
      hmlv_pkg::PH_BETWEEN: begin
        if (c == hmlv_pkg::CH_SPACE) begin
        end else if (c == hmlv_pkg::CH_PLUS || c == hmlv_pkg::CH_MINUS || dec_char(c)) begin
          open_token();
          if (ph != hmlv_pkg::PH_SKIP) begin
            if (dec_char(c)) begin
              push_digit(c);
              ph = hmlv_pkg::PH_DIGITS;
            end else begin
              tok_neg = (c == hmlv_pkg::CH_MINUS);
              ph = hmlv_pkg::PH_SIGN;
            end
          end
        end else begin
          mark_fault(hmlv_pkg::ST_BAD);
        end
      end
      hmlv_pkg::PH_SIGN: begin
        if (dec_char(c)) begin
          push_digit(c);
          ph = hmlv_pkg::PH_DIGITS;
        end else begin
          mark_fault(hmlv_pkg::ST_BAD);
        end
      end
      hmlv_pkg::PH_DIGITS: begin
        if (dec_char(c)) begin
          push_digit(c);
        end else if (c == hmlv_pkg::CH_SPACE) begin
          commit_height();
          ph = hmlv_pkg::PH_BETWEEN;
        end else if (c == hmlv_pkg::CH_COMMA) begin
          commit_height();
          ph = hmlv_pkg::PH_COMMA;
        end else begin
          mark_fault(hmlv_pkg::ST_BAD);
        end
      end
      hmlv_pkg::PH_COMMA: begin
        if (c == hmlv_pkg::CH_ZERO) ph = hmlv_pkg::PH_ZERO;
        else mark_fault(hmlv_pkg::ST_BAD);
      end
      hmlv_pkg::PH_ZERO: begin
        if (c == hmlv_pkg::CH_X) ph = hmlv_pkg::PH_HEX;
        else mark_fault(hmlv_pkg::ST_BAD);
      end
      hmlv_pkg::PH_HEX: begin
        if (c == hmlv_pkg::CH_SPACE && hex_n != 0) ph = hmlv_pkg::PH_BETWEEN;
        else if (hex_char(c) && hex_n < 3'(MAX_HEX)) hex_n = hex_n + 3'd1;
        else mark_fault(hmlv_pkg::ST_BAD);
      end
      default: begin
      end
    endcase
  endfunction

  // end of line: finish the token, check width, build the report
  function automatic void close_line(output line_report_t rep);
    hmlv_pkg::status_t st;
    if (ph == hmlv_pkg::PH_DIGITS) commit_height();
    else if (ph == hmlv_pkg::PH_SIGN || ph == hmlv_pkg::PH_COMMA || ph == hmlv_pkg::PH_ZERO ||
             (ph == hmlv_pkg::PH_HEX && hex_n == 0))
      mark_fault(hmlv_pkg::ST_BAD);
    if (fault_code == hmlv_pkg::ST_OK) begin
      if (!width_set) begin
        want_cols = cols;
        width_set = 1'b1;
      end else if (want_cols != cols) begin
        fault_code = hmlv_pkg::ST_WIDTH;
      end
    end
    if (line_cnt != hmlv_pkg::LINES_MAX) line_cnt = line_cnt + 16'd1;
    st = fault_code;
    if (st != hmlv_pkg::ST_OK) failed = 1'b1;
    else if (failed) st = hmlv_pkg::ST_BAD;
    rep = '{st, cols, line_cnt, lo, hi};
    ph = hmlv_pkg::PH_BETWEEN;
    hex_n = '0;
    tok_val = '0;
    tok_neg = 1'b0;
    cols = '0;
    fault_code = hmlv_pkg::ST_OK;
  endfunction

  function automatic void add_row(string text, bit typed = 0, line_report_t want = '0,
                                  int reps = 1, logic [7:0] tail = 8'h00, bit has_tail = 0);
    map_row_t r;
    r.text = text;
    r.typed = typed;
    r.want = want;
    r.reps = reps;
    r.tail = tail;
    r.has_tail = has_tail;
    rows.push_back(r);
  endfunction

  // offer one transaction in bursts with random gaps, then predict on acceptance
  task automatic put_item(logic [7:0] c, logic eol, bit typed, line_report_t want);
    line_report_t rep;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= eol;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (eol) begin
      close_line(rep);
      reports_due.push_back(typed ? want : rep);
      lines_sent++;
    end else begin
      feed_char(c);
    end
    @(negedge clk);
  endtask

  task automatic send_line(bit typed, line_report_t want);
    foreach (line_buf[i]) put_item(line_buf[i], 1'b0, 1'b0, '0);
    put_item(8'($urandom_range(0, 255)), 1'b1, typed, want);
  endtask

  // mostly well-formed lines with random content, some noise and damage
  task automatic make_random_line();
    string hex_set;
    int    kind;
    int    ntok;
    int    ndig;
    int    nhex;
    int    pos;
    hex_set = "0123456789abcdefABCDEF";
    line_buf.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
    end else if (kind != 1) begin
      if ($urandom_range(0, 3) == 0) line_buf.push_back(hmlv_pkg::CH_SPACE);
      ntok = $urandom_range(1, 5);
      for (int t = 0; t < ntok; t++) begin
        case ($urandom_range(0, 3))
          1: line_buf.push_back(hmlv_pkg::CH_PLUS);
          2: line_buf.push_back(hmlv_pkg::CH_MINUS);
          default: begin
          end
        endcase
        ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
        repeat (ndig) line_buf.push_back(8'(hmlv_pkg::CH_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 2) == 0) begin
          line_buf.push_back(hmlv_pkg::CH_COMMA);
          line_buf.push_back(hmlv_pkg::CH_ZERO);
          line_buf.push_back(hmlv_pkg::CH_X);
          nhex = ($urandom_range(0, 15) == 0) ? MAX_HEX + 1 : $urandom_range(1, MAX_HEX);
          repeat (nhex) line_buf.push_back(hex_set[$urandom_range(0, 21)]);
        end
        if (t != ntok - 1 || $urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 2)) line_buf.push_back(hmlv_pkg::CH_SPACE);
      end
      // damage: overwrite one byte or cut the line short
      if ($urandom_range(0, 4) == 0) begin
        pos = $urandom_range(0, line_buf.size() - 1);
        if ($urandom_range(0, 1) == 0) line_buf[pos] = 8'($urandom_range(0, 255));
        else while (line_buf.size() > pos) void'(line_buf.pop_back());
      end
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("[height_map_line_validator_unit] ERROR");
    $finish;
  end

  // receiver: ready pattern in spans, one long hold-off on request
  initial begin
    int mode;
    int span;
    m_axis_tready = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          m_axis_tready <= 1'b0;
        end
        hold_done = 1'b1;
      end else begin
        mode = stim_done ? 0 : $urandom_range(0, 3);
        span = $urandom_range(5, 60);
        repeat (span) begin
          @(negedge clk);
          case (mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ($urandom_range(0, 1) != 0);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  // compare each report transaction with the oldest expectation
  always @(posedge clk) begin : watch_reports
    line_report_t got;
    line_report_t exp;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = hmlv_pkg::status_t'(m_axis_tdata[1:0]);
      got.cols   = m_axis_tdata[14:2];
      got.line   = m_axis_tdata[30:15];
      got.lo     = m_axis_tdata[62:31];
      got.hi     = m_axis_tdata[94:63];
      reports_seen++;
      status_seen[m_axis_tdata[1:0]]++;
      if (reports_due.size() == 0) begin
        $error("report for line %0d arrived with nothing expected", got.line);
        mismatches++;
      end else begin
        exp = reports_due.pop_front();
        if (got.status != exp.status) begin
          $error("line_status: expected %0d, got %0d", exp.status, got.status);
          mismatches++;
        end
        if (got.cols != exp.cols) begin
          $error("column_count: expected %0d, got %0d", exp.cols, got.cols);
          mismatches++;
        end
        if (got.line != exp.line) begin
          $error("line_number: expected %0d, got %0d", exp.line, got.line);
          mismatches++;
        end
        if (got.lo != exp.lo) begin
          $error("lowest height: expected %0d, got %0d", exp.lo, got.lo);
          mismatches++;
        end
        if (got.hi != exp.hi) begin
          $error("highest height: expected %0d, got %0d", exp.hi, got.hi);
          mismatches++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int start;
    int waited;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    s_axis_tlast = 1'b0;
    burst_left = 0;
    items_sent = 0;
    lines_sent = 0;
    reports_seen = 0;
    mismatches = 0;
    status_seen = '{0, 0, 0, 0};
    hold_req = 1'b0;
    hold_done = 1'b0;
    stim_done = 1'b0;
    ph = hmlv_pkg::PH_BETWEEN;
    hex_n = '0;
    tok_val = '0;
    tok_neg = 1'b0;
    cols = '0;
    want_cols = '0;
    width_set = 1'b0;
    lo = '0;
    hi = '0;
    heights_set = 1'b0;
    line_cnt = '0;
    fault_code = hmlv_pkg::ST_OK;
    failed = 1'b0;

    // empty first lines fix width zero and show heights before any number
    add_row("", 1, '{hmlv_pkg::ST_OK, 13'd0, 16'd1, 32'sd0, 32'sd0});
    add_row("", 1, '{hmlv_pkg::ST_OK, 13'd0, 16'd2, 32'sd0, 32'sd0});
    // first number sets both bounds
    add_row("9 12", 1, '{hmlv_pkg::ST_WIDTH, 13'd2, 16'd3, 32'sd9, 32'sd12});
    add_row(" -5 +7  ", 1, '{hmlv_pkg::ST_WIDTH, 13'd2, 16'd4, -32'sd5, 32'sd12});
    // exact magnitude limit on both sides
    add_row("2147483648 -2147483648", 1,
            '{hmlv_pkg::ST_WIDTH, 13'd2, 16'd5, 32'sh8000_0000, 32'sh7FFF_FFFF});
    add_row("99999999999999 -99999999999999,0x0");
    add_row("1,0xABCDEF 2,0xff 3,0x9");
    add_row("3,0x1234567");
    // unfinished tokens
    add_row("+");
    add_row("4,");
    add_row("4,0");
    add_row("4,0x");
    add_row("4,0x 5");
    // stray bytes
    add_row("1\t2");
    add_row("X");
    add_row("7", 0, '0, 1, 8'h00, 1);
    add_row("8", 0, '0, 1, 8'hFF, 1);
    add_row("5,0X1");
    // only the first fault of a line counts
    add_row("1 - 2");
    add_row("1 2 3 4x 5 6");
    add_row("-0 +0");
    // clean line after failure
    add_row("");

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[k]) begin
      line_buf.delete();
      repeat (rows[k].reps)
        for (int i = 0; i < rows[k].text.len(); i++) line_buf.push_back(rows[k].text[i]);
      if (rows[k].has_tail) line_buf.push_back(rows[k].tail);
      send_line(rows[k].typed, rows[k].want);
    end

    // random lines, with one long receiver hold-off early on
    hold_req = 1'b1;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      make_random_line();
      send_line(1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;

    waited = 0;
    while (reports_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (reports_due.size() != 0) begin
      $display("timed out with %0d reports outstanding", reports_due.size());
      $display("[height_map_line_validator_unit] ERROR");
    end else begin
      repeat (20) @(posedge clk);
      $display("sent %0d transactions over %0d lines, %0d reports checked, %0d mismatches",
               items_sent, lines_sent, reports_seen, mismatches);
      $display("status ok %0d, bad token %0d, width %0d, columns %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (mismatches == 0 && reports_due.size() == 0)
        $display("[height_map_line_validator_unit] OK");
      else
        $display("[height_map_line_validator_unit] ERROR");
    end
    $finish;
  end

endmodule
